[rtl/core/blps_pkg.sv]
// Package for the battery LED pattern sequencer: types, codes, tables.
// No dependencies; used by every module in rtl/core.
package blps_pkg;

    localparam int unsigned TICKS_PER_BEAT_DEF = 2;
    localparam int unsigned PORT_COUNT_DEF     = 2;
    localparam int unsigned FRAC_BITS_DEF      = 4;

    localparam logic [1:0] SIDE_LEFT  = 2'd0;
    localparam logic [1:0] SIDE_BOTH  = 2'd2;
    localparam logic [2:0] COL_OFF    = 3'd0;
    localparam logic [2:0] COL_GREEN  = 3'd2;
    localparam logic [2:0] COL_WHITE  = 3'd4;
    localparam logic [3:0] PAT_GREEN  = 4'd0;
    localparam logic [3:0] PAT_WHITE  = 4'd2;
    localparam logic [3:0] PAT_WHITE_RED = 4'd3;
    localparam logic [3:0] PAT_BLINK  = 4'd7;
    localparam logic [3:0] PAT_OFF    = 4'd8;
    localparam logic [1:0] CS_CHARGING  = 2'd0;
    localparam logic [1:0] CS_NEAR_FULL = 2'd1;
    localparam logic [1:0] CS_DIS_FULL  = 2'd2;
    localparam logic [1:0] CS_OTHER     = 2'd3;
    localparam logic       REG_MANUAL_HOLD = 1'b0;
    localparam logic       REG_MIN_SOC     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_OFF_SIDE,
        ST_FADE_SETUP,
        ST_FADE,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic load_item;
        logic decide;
        logic emit_off;
        logic fade_setup;
        logic fade_step;
        logic emit_final;
    } cmd_t;

    typedef struct packed {
        logic run;       // tick that produces output
        logic one_side;
        logic recolour;
        logic fade_done;
    } status_t;

    typedef struct packed {
        logic [1:0] led_select;
        logic [6:0] red_level;
        logic [6:0] green_level;
        logic [6:0] blue_level;
        logic       fade_step;
        logic       last;
    } result_t;

    function automatic logic [6:0] hsi_ramp(input logic [3:0] i);
        logic [6:0] r;
        begin
            case (i)
                4'd0: r = 7'd0;
                4'd1: r = 7'd5;
                4'd2: r = 7'd13;
                4'd3: r = 7'd22;
                4'd4: r = 7'd33;
                4'd5: r = 7'd47;
                4'd6: r = 7'd63;
                4'd7: r = 7'd80;
                default: r = 7'd100;
            endcase
            return r;
        end
    endfunction

    function automatic logic [20:0] rgb_of(input logic [2:0] c);
        logic [20:0] r;
        begin
            case (c)
                3'd1: r = {7'd0, 7'd0, 7'd80};
                3'd2: r = {7'd0, 7'd80, 7'd0};
                3'd3: r = {7'd80, 7'd0, 7'd0};
                3'd4: r = {7'd100, 7'd100, 7'd100};
                3'd5: r = {7'd0, 7'd0, 7'd40};
                3'd6: r = {7'd0, 7'd0, 7'd20};
                default: r = '0;
            endcase
            return r; // {blue, green, red}
        end
    endfunction

    function automatic logic [5:0] pat_color(input logic [3:0] p);
        logic [5:0] r;
        begin
            case (p)
                4'd0: r = {3'd2, 3'd2};
                4'd1: r = {3'd4, 3'd2};
                4'd2: r = {3'd4, 3'd4};
                4'd3: r = {3'd4, 3'd1};
                4'd4: r = {3'd1, 3'd1};
                4'd5: r = {3'd1, 3'd5};
                4'd6: r = {3'd1, 3'd6};
                4'd7: r = {3'd1, 3'd0};
                default: r = '0;
            endcase
            return r; // {phase0, phase1}
        end
    endfunction

    function automatic logic [5:0] pat_len(input logic [3:0] p);
        logic [5:0] r;
        begin
            case (p)
                4'd1, 4'd3, 4'd6: r = {3'd2, 3'd4};
                4'd5: r = {3'd4, 3'd4};
                4'd7: r = {3'd1, 3'd6};
                default: r = '0;
            endcase
            return r; // {len0, len1}
        end
    endfunction

endpackage

[rtl/core/blps_ctrl.sv]
// Controller state machine of the battery LED pattern sequencer.
// Depends on blps_pkg.
module blps_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_busy,
    input  blps_pkg::status_t status,
    output blps_pkg::cmd_t    cmd,
    output logic              idle
);

    blps_pkg::state_t state_reg;
    blps_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= blps_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            blps_pkg::ST_IDLE:
                if (in_fire)
                    state_next = blps_pkg::ST_DECIDE;
            blps_pkg::ST_DECIDE:
                if (!status.run)
                    state_next = blps_pkg::ST_IDLE;
                else if (status.one_side)
                    state_next = blps_pkg::ST_OFF_SIDE;
                else if (status.recolour)
                    state_next = blps_pkg::ST_FADE_SETUP;
                else
                    state_next = blps_pkg::ST_FINAL;
            blps_pkg::ST_OFF_SIDE:
                if (!out_busy)
                    state_next = status.recolour ? blps_pkg::ST_FADE_SETUP
                                                 : blps_pkg::ST_FINAL;
            blps_pkg::ST_FADE_SETUP:
                state_next = blps_pkg::ST_FADE;
            blps_pkg::ST_FADE:
                if (!out_busy && status.fade_done)
                    state_next = blps_pkg::ST_FINAL;
            blps_pkg::ST_FINAL:
                if (!out_busy)
                    state_next = blps_pkg::ST_IDLE;
            default:
                state_next = blps_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        idle = 1'b0;
        unique case (state_reg)
            blps_pkg::ST_IDLE:
            begin
                idle          = 1'b1;
                cmd.load_item = in_fire;
            end
            blps_pkg::ST_DECIDE:     cmd.decide     = 1'b1;
            blps_pkg::ST_OFF_SIDE:   cmd.emit_off   = !out_busy;
            blps_pkg::ST_FADE_SETUP: cmd.fade_setup = 1'b1;
            blps_pkg::ST_FADE:       cmd.fade_step  = !out_busy;
            blps_pkg::ST_FINAL:      cmd.emit_final = !out_busy;
            default:                 cmd            = '0;
        endcase
    end

endmodule

[rtl/core/blps_datapath.sv]
// Datapath of the battery LED pattern sequencer: state, pattern choice, fade.
// Depends on blps_pkg.
module blps_datapath #(
    parameter int unsigned TICKS_PER_BEAT = blps_pkg::TICKS_PER_BEAT_DEF,
    parameter int unsigned PORT_COUNT     = blps_pkg::PORT_COUNT_DEF,
    parameter int unsigned FRAC_BITS      = blps_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  blps_pkg::cmd_t     cmd,
    input  logic [16:0]        item,
    input  logic               manual_hold,
    input  logic [1:0]         min_soc,
    output blps_pkg::status_t  status,
    output blps_pkg::result_t  result
);

    localparam int unsigned TAP_LEN = TICKS_PER_BEAT * 8;
    localparam int unsigned PH_W    = $clog2(TICKS_PER_BEAT * 8);
    localparam int unsigned TAP_W   = $clog2(TAP_LEN + 1);
    localparam int unsigned ACC_W   = 7 + FRAC_BITS + 1;

    logic [16:0]       item_reg;
    logic [3:0]        pat_reg, pat_next;
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [2:0]        shown_reg;
    logic [TAP_W-1:0]  tap_cnt_reg, tap_cnt_next;
    logic              tap_pend_reg;
    logic [1:0]        side_reg;
    logic [2:0]        color_reg, from_reg;
    logic [6:0]        cur_reg [3];
    logic [6:0]        tgt_reg [3];
    logic              up_reg, hsi_reg;
    logic [3:0]        step_reg;
    logic [6:0]        lo_reg;
    logic [ACC_W-1:0]  delta_reg;

    logic        req, ext, chip, auto_en, tap, run;
    logic [1:0]  cs;
    logic [3:0]  port;
    logic [6:0]  pct_raw, pct;
    logic [1:0]  side;
    logic [3:0]  band_pat, pat_sel, pat_fix;
    logic [2:0]  len0, len1;
    logic [2:0]  color;
    logic [5:0]  colors;
    logic [PH_W:0] ph_lim0, ph_lim;

    assign {auto_en, pct_raw, port, chip, ext, cs, req} = item_reg;

    always_comb
    begin
        run  = !req && auto_en && !manual_hold;
        tap  = tap_pend_reg && !chip;
        side = (port[3] || ({28'd0, port} >= 32'(PORT_COUNT))) ? blps_pkg::SIDE_BOTH
                                                              : port[1:0];
        pct  = (pct_raw > 7'd100) ? 7'd100 : pct_raw;
        if (pct <= 7'd3)       band_pat = 4'd6;
        else if (pct <= 7'd9)  band_pat = 4'd5;
        else if (pct <= 7'd14) band_pat = 4'd4;
        else if (pct <= 7'd29) band_pat = 4'd3;
        else if (pct <= 7'd89) band_pat = 4'd2;
        else if (pct <= 7'd97) band_pat = 4'd1;
        else                   band_pat = 4'd0;
        pat_sel      = pat_reg;
        tap_cnt_next = tap_cnt_reg;
        if (cs == blps_pkg::CS_NEAR_FULL || (cs == blps_pkg::CS_DIS_FULL && ext))
        begin
            pat_sel      = blps_pkg::PAT_GREEN;
            tap_cnt_next = '0;
        end
        else if (cs == blps_pkg::CS_CHARGING)
        begin
            pat_sel      = blps_pkg::PAT_WHITE;
            tap_cnt_next = '0;
        end
        else if (tap_cnt_reg == '0)
        begin
            if (min_soc != 2'd0 && ({1'b0, pct} + 8'd1 <= {6'd0, min_soc}))
                pat_sel = blps_pkg::PAT_BLINK;
            else
                pat_sel = band_pat;
            if (!tap && pat_sel <= blps_pkg::PAT_WHITE_RED)
                pat_sel = blps_pkg::PAT_OFF;
            else
                tap_cnt_next = TAP_W'(TAP_LEN);
        end
        pat_fix    = (pat_sel > blps_pkg::PAT_OFF) ? blps_pkg::PAT_OFF : pat_sel;
        pat_next   = pat_fix;
        phase_next = (pat_sel != pat_reg) ? '0 : phase_reg;
        {len0, len1} = blps_pkg::pat_len(pat_fix);
        colors     = blps_pkg::pat_color(pat_fix);
        ph_lim0    = (PH_W+1)'(TICKS_PER_BEAT * len0);
        ph_lim     = (PH_W+1)'(TICKS_PER_BEAT * ({1'b0, len0} + {1'b0, len1}));
        color      = ({1'b0, phase_next} < ph_lim0) ? colors[5:3] : colors[2:0];
    end

    // fade ramp value at the current step
    logic [6:0]       ramp;
    logic [ACC_W-1:0] acc;
    logic [6:0]       nxt [3];
    logic             moved;
    logic [20:0]      rgb_from, rgb_to;
    logic [6:0]       fc, ft;
    logic             ci;

    always_comb
    begin
        acc  = ACC_W'(delta_reg * step_reg) + ACC_W'(1 << (FRAC_BITS - 1));
        ramp = hsi_reg ? blps_pkg::hsi_ramp(step_reg)
                       : 7'(lo_reg + 7'(acc >> FRAC_BITS));
        moved = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            nxt[i] = cur_reg[i];
            if (up_reg)
            begin
                if (cur_reg[i] < tgt_reg[i] && cur_reg[i] <= ramp)
                begin
                    nxt[i] = (ramp < tgt_reg[i]) ? ramp : tgt_reg[i];
                    moved  = 1'b1;
                end
            end
            else if (cur_reg[i] > tgt_reg[i] && cur_reg[i] >= ramp)
            begin
                nxt[i] = (ramp > tgt_reg[i]) ? ramp : tgt_reg[i];
                moved  = 1'b1;
            end
        end
        rgb_from = blps_pkg::rgb_of(from_reg);
        rgb_to   = blps_pkg::rgb_of(color_reg);
        ci = (from_reg == blps_pkg::COL_GREEN || color_reg == blps_pkg::COL_GREEN);
        fc = ci ? rgb_from[13:7] : rgb_from[6:0];
        ft = ci ? rgb_to[13:7] : rgb_to[6:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg      <= blps_pkg::PAT_OFF;
            phase_reg    <= '0;
            shown_reg    <= blps_pkg::COL_OFF;
            tap_cnt_reg  <= '0;
            tap_pend_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item && item[0])
                tap_pend_reg <= 1'b1;
            if (cmd.decide && run)
            begin
                tap_pend_reg <= 1'b0;
                pat_reg      <= pat_next;
                color_reg    <= color;
                from_reg     <= shown_reg;
                shown_reg    <= color;
                side_reg     <= side;
                if (len0 != 3'd0)
                    phase_reg <= ({1'b0, phase_next} + 1'b1 >= ph_lim) ? '0
                                                                       : phase_next + 1'b1;
                else
                    phase_reg <= phase_next;
                tap_cnt_reg  <= (tap_cnt_next != '0) ? tap_cnt_next - 1'b1 : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= item;
        if (cmd.fade_setup)
        begin
            up_reg  <= (rgb_from[6:0] < rgb_to[6:0]) || (rgb_from[13:7] < rgb_to[13:7])
                    || (rgb_from[20:14] < rgb_to[20:14]);
            step_reg <= ((rgb_from[6:0] < rgb_to[6:0]) || (rgb_from[13:7] < rgb_to[13:7])
                    || (rgb_from[20:14] < rgb_to[20:14])) ? 4'd1 : 4'd7;
            hsi_reg  <= (from_reg == blps_pkg::COL_WHITE || color_reg == blps_pkg::COL_WHITE);
            lo_reg   <= (fc > ft) ? ft : fc;
            delta_reg <= (ACC_W'((fc > ft) ? fc - ft : ft - fc) << FRAC_BITS) >> 3;
            for (int i = 0; i < 3; i++)
            begin
                cur_reg[i] <= rgb_from[7*i +: 7];
                tgt_reg[i] <= rgb_to[7*i +: 7];
            end
        end
        if (cmd.fade_step)
        begin
            for (int i = 0; i < 3; i++)
                cur_reg[i] <= nxt[i];
            step_reg <= up_reg ? step_reg + 1'b1 : step_reg - 1'b1;
        end
    end

    logic [20:0] fin;
    always_comb
    begin
        fin = blps_pkg::rgb_of(color_reg);
        status.run       = run;
        // while deciding, route on the values about to be registered
        status.one_side  = cmd.decide ? (side != blps_pkg::SIDE_BOTH)
                                      : (side_reg != blps_pkg::SIDE_BOTH);
        status.recolour  = cmd.decide ? (shown_reg != color) : (from_reg != color_reg);
        status.fade_done = !moved || (up_reg ? (step_reg == 4'd8) : (step_reg == 4'd0));
        result = '0;
        if (cmd.emit_off)
            result.led_select = side_reg ^ 2'd1;
        else if (cmd.fade_step)
        begin
            result.led_select  = side_reg;
            result.red_level   = nxt[0];
            result.green_level = nxt[1];
            result.blue_level  = nxt[2];
            result.fade_step   = 1'b1;
        end
        else
        begin
            result.led_select  = side_reg;
            result.red_level   = fin[6:0];
            result.green_level = fin[13:7];
            result.blue_level  = fin[20:14];
            result.last        = 1'b1;
        end
    end

endmodule

[rtl/core/battery_led_pattern_sequencer_unit.sv]
// Top level of the battery LED pattern sequencer.
// Depends on blps_pkg, blps_ctrl and blps_datapath.
//
// One input transfer is taken at a time. A double tap or an ignored tick
// passes through the decide state and back to idle. A producing tick
// decides the pattern, then issues each result in turn (the opposite-LED off
// write, 1 to 8 fade writes and the final write), with a fade setup step
// when the colour changes. While the output register is free, the sequencer
// steps one fade write a cycle through the shared ramp unit. Results sit in
// an output register, so the next input is taken while the final one waits.
module battery_led_pattern_sequencer_unit #(
    parameter int unsigned TICKS_PER_BEAT = blps_pkg::TICKS_PER_BEAT_DEF,
    parameter int unsigned PORT_COUNT     = blps_pkg::PORT_COUNT_DEF,
    parameter int unsigned FRAC_BITS      = blps_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // chg_state[1:0], ext_power[2], chipset_on[3], active_port[7:4],
    // battery_percent[14:8], auto_enabled[15]
    input  logic [15:0] s_axis_tdata,
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // led_select[1:0], red_level[8:2], green_level[15:9], blue_level[22:16]
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tuser,   // fade_step
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data
);

    blps_pkg::cmd_t    cmd;
    blps_pkg::status_t status;
    blps_pkg::result_t result;
    logic              idle;
    logic              out_busy;
    logic              manual_hold_reg;
    logic [1:0]        min_soc_reg;
    logic              in_fire;

    // output register: a write to it is blocked only while a result is held
    assign out_busy      = m_axis_tvalid && !m_axis_tready;
    assign s_axis_tready = idle;
    assign in_fire       = s_axis_tvalid && idle;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            manual_hold_reg <= 1'b0;
            min_soc_reg     <= 2'd2;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                blps_pkg::REG_MANUAL_HOLD: manual_hold_reg <= cfg_data[0];
                blps_pkg::REG_MIN_SOC:     min_soc_reg     <= cfg_data;
                default:                   manual_hold_reg <= manual_hold_reg;
            endcase
        end
    end

    blps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_busy (out_busy),
        .status   (status),
        .cmd      (cmd),
        .idle     (idle)
    );

    blps_datapath #(
        .TICKS_PER_BEAT (TICKS_PER_BEAT),
        .PORT_COUNT     (PORT_COUNT),
        .FRAC_BITS      (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .item        ({s_axis_tdata[15:0], s_axis_tuser}),
        .manual_hold (manual_hold_reg),
        .min_soc     (min_soc_reg),
        .status      (status),
        .result      (result)
    );

    logic load_out;
    assign load_out = cmd.emit_off || cmd.fade_step || cmd.emit_final;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tvalid <= 1'b0;
        else if (load_out)
            m_axis_tvalid <= 1'b1;
        else if (m_axis_tready)
            m_axis_tvalid <= 1'b0;
    end

    // hold the payload until taken
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_axis_tdata <= {1'b0, result.blue_level, result.green_level,
                             result.red_level, result.led_select};
            m_axis_tuser <= result.fade_step;
            m_axis_tlast <= result.last;
        end
    end

endmodule

[test/tb_battery_led_pattern_sequencer_unit.sv]
// Self-checking testbench for battery_led_pattern_sequencer_unit.
// Depends on blps_pkg and the RTL in rtl/core; predicts every LED write in
// the testbench and checks each output transfer against it in order.
module tb_battery_led_pattern_sequencer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TPB = 2;
    localparam int TAP_LEN = TPB * 8;

    typedef struct packed {
        logic       req_type;
        logic [1:0] chg_state;
        logic       ext_power;
        logic       chipset_on;
        logic [3:0] active_port;
        logic [6:0] battery_percent;
        logic       auto_enabled;
    } led_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [1:0]  cfg_data = '0;

    battery_led_pattern_sequencer_unit dut (.*);

    always #5 clk = ~clk;

    // Model state
    logic       hold_q;
    logic [1:0] min_soc_q;
    logic [3:0] pat_q;
    logic [4:0] phase_q;
    logic [2:0] colour_q;
    logic [5:0] tap_cnt_q;
    logic       tap_pend_q;

    blps_pkg::result_t led_writes_q[$];
    int  fails = 0;
    bit  no_gaps = 0;
    int  stall_left = 0;

    // Colour table as red, green, blue levels.
    function automatic logic [20:0] colour_rgb(input logic [2:0] c);
        case (c)
            3'd1: return {7'd80, 7'd0, 7'd0};
            3'd2: return {7'd0, 7'd80, 7'd0};
            3'd3: return {7'd0, 7'd0, 7'd80};
            3'd4: return {7'd100, 7'd100, 7'd100};
            3'd5: return {7'd40, 7'd0, 7'd0};
            3'd6: return {7'd20, 7'd0, 7'd0};
            default: return '0;
        endcase
    endfunction

    function automatic int hsi_level(input int i);
        int t[9] = '{0, 5, 13, 22, 33, 47, 63, 80, 100};
        return t[i];
    endfunction

    function automatic void push_write(input logic [1:0] sel, input int r, input int g,
                                       input int b, input logic fstep);
        blps_pkg::result_t w;
        w.led_select = sel;
        w.red_level = r[6:0];
        w.green_level = g[6:0];
        w.blue_level = b[6:0];
        w.fade_step = fstep;
        w.last = 1'b0;
        led_writes_q.push_back(w);
    endfunction

    function automatic void predict_fade(input logic [2:0] from, input logic [2:0] to,
                                         input logic [1:0] sel);
        int cur[3], tgt[3], ramp[9];
        logic [20:0] a, z;
        bit up, moved, done;
        int step, ci, lo, span, delta, acc;
        a = colour_rgb(from);
        z = colour_rgb(to);
        up = 0;
        for (int i = 0; i < 3; i++)
        begin
            cur[i] = a[20 - 7*i -: 7];
            tgt[i] = z[20 - 7*i -: 7];
            if (cur[i] < tgt[i]) up = 1;
        end
        if (from == blps_pkg::COL_WHITE || to == blps_pkg::COL_WHITE)
        begin
            for (int i = 0; i < 9; i++) ramp[i] = hsi_level(i);
        end
        else
        begin
            ci = (from == blps_pkg::COL_GREEN || to == blps_pkg::COL_GREEN) ? 1 : 0;
            lo = (cur[ci] > tgt[ci]) ? tgt[ci] : cur[ci];
            span = (cur[ci] > tgt[ci]) ? cur[ci] - tgt[ci] : tgt[ci] - cur[ci];
            delta = (span << 4) / 8;
            acc = 0;
            for (int i = 0; i < 9; i++)
            begin
                ramp[i] = lo + ((acc + 8) >> 4);
                acc += delta;
            end
        end
        step = up ? 1 : 7;
        done = 0;
        while (!done)
        begin
            moved = 0;
            for (int i = 0; i < 3; i++)
            begin
                if (up && cur[i] < tgt[i] && cur[i] <= ramp[step])
                begin
                    cur[i] = ramp[step] < tgt[i] ? ramp[step] : tgt[i];
                    moved = 1;
                end
                else if (!up && cur[i] > tgt[i] && cur[i] >= ramp[step])
                begin
                    cur[i] = ramp[step] > tgt[i] ? ramp[step] : tgt[i];
                    moved = 1;
                end
            end
            if (up) begin step++; done = !moved || step >= 9; end
            else begin step--; done = !moved || step < 0; end
            push_write(sel, cur[0], cur[1], cur[2], 1'b1);
        end
    endfunction

    // Advance the model by one accepted item and queue its LED writes.
    function automatic void predict_item(input led_req_t q);
        logic [1:0] sel;
        logic [3:0] pat;
        logic [2:0] col;
        int pct, len0, len1, bmax[7], bpat[7];
        logic [5:0] lens, cols;
        bit tap;
        logic [20:0] rgb;
        bmax = '{3, 9, 14, 29, 89, 97, 100};
        bpat = '{6, 5, 4, 3, 2, 1, 0};
        tap = 0;
        if (q.req_type)
        begin
            tap_pend_q = 1'b1;
            return;
        end
        if (hold_q || !q.auto_enabled) return;
        if (tap_pend_q)
        begin
            tap = !q.chipset_on;
            tap_pend_q = 1'b0;
        end
        sel = (q.active_port[3] || q.active_port >= 2) ? blps_pkg::SIDE_BOTH
                                                       : q.active_port[1:0];
        pct = (q.battery_percent > 100) ? 100 : q.battery_percent;
        pat = pat_q;
        if (q.chg_state == blps_pkg::CS_NEAR_FULL
            || (q.chg_state == blps_pkg::CS_DIS_FULL && q.ext_power))
        begin
            pat = blps_pkg::PAT_GREEN;
            tap_cnt_q = 0;
        end
        else if (q.chg_state == blps_pkg::CS_CHARGING)
        begin
            pat = blps_pkg::PAT_WHITE;
            tap_cnt_q = 0;
        end
        else if (tap_cnt_q == 0)
        begin
            if (min_soc_q != 0 && pct + 1 <= min_soc_q)
                pat = blps_pkg::PAT_BLINK;
            else
                for (int i = 0; i < 7; i++)
                    if (pct <= bmax[i])
                    begin
                        pat = 4'(bpat[i]);
                        break;
                    end
            if (!tap && pat <= blps_pkg::PAT_WHITE_RED) pat = blps_pkg::PAT_OFF;
            else tap_cnt_q = 6'(TAP_LEN);
        end
        if (pat != pat_q)
        begin
            phase_q = 0;
            pat_q = pat;
        end
        if (sel != blps_pkg::SIDE_BOTH) push_write(sel ^ 2'd1, 0, 0, 0, 1'b0);
        lens = blps_pkg::pat_len(pat_q);
        cols = blps_pkg::pat_color(pat_q);
        len0 = lens[5:3];
        len1 = lens[2:0];
        col = (phase_q < TPB * len0) ? cols[5:3] : cols[2:0];
        if (colour_q != col)
        begin
            predict_fade(colour_q, col, sel);
            colour_q = col;
        end
        rgb = colour_rgb(col);
        push_write(sel, rgb[20:14], rgb[13:7], rgb[6:0], 1'b0);
        led_writes_q[$].last = 1'b1;
        if (len0 != 0)
        begin
            phase_q++;
            if (phase_q >= TPB * (len0 + len1)) phase_q = 0;
        end
        if (tap_cnt_q != 0) tap_cnt_q--;
    endfunction

    // Check each output transfer against the oldest queued write.
    always @(posedge clk)
    begin
        blps_pkg::result_t exp_w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (led_writes_q.size() == 0)
            begin
                $error("unexpected LED write %h", m_axis_tdata);
                fails++;
            end
            else
            begin
                exp_w = led_writes_q.pop_front();
                if (m_axis_tdata[1:0] !== exp_w.led_select)
                begin
                    $error("led_select exp %0d got %0d", exp_w.led_select, m_axis_tdata[1:0]);
                    fails++;
                end
                if (m_axis_tdata[8:2] !== exp_w.red_level)
                begin
                    $error("red_level exp %0d got %0d", exp_w.red_level, m_axis_tdata[8:2]);
                    fails++;
                end
                if (m_axis_tdata[15:9] !== exp_w.green_level)
                begin
                    $error("green_level exp %0d got %0d", exp_w.green_level,
                           m_axis_tdata[15:9]);
                    fails++;
                end
                if (m_axis_tdata[22:16] !== exp_w.blue_level)
                begin
                    $error("blue_level exp %0d got %0d", exp_w.blue_level,
                           m_axis_tdata[22:16]);
                    fails++;
                end
                if (m_axis_tuser !== exp_w.fade_step)
                begin
                    $error("fade_step exp %0d got %0d", exp_w.fade_step, m_axis_tuser);
                    fails++;
                end
                if (m_axis_tlast !== exp_w.last)
                begin
                    $error("last exp %0d got %0d", exp_w.last, m_axis_tlast);
                    fails++;
                end
            end
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if (no_gaps) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(5, 25);
        return $urandom_range(0, 2);
    endfunction

    // Receiver stalls: mostly short, now and then a long one.
    always @(posedge clk)
    begin
        if (no_gaps)
            m_axis_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = gap_len();
        end
        else
            m_axis_tready <= 1'b1;
    end

    // The block is never ready in the cycle after a transfer, so the task
    // always waits before raising valid again.
    task automatic send_item(input led_req_t q);
        int g;
        g = gap_len();
        repeat (g + 1) @(posedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= q.req_type;
        s_axis_tdata <= {q.auto_enabled, q.battery_percent, q.active_port,
                         q.chipset_on, q.ext_power, q.chg_state};
        do @(posedge clk); while (!s_axis_tready);
        predict_item(q);
        s_axis_tvalid <= 1'b0;
    endtask

    // Drain the expected writes, then let the block settle before a write.
    task automatic wait_idle();
        wait (led_writes_q.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [1:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == blps_pkg::REG_MANUAL_HOLD) hold_q = val[0];
        else min_soc_q = val;
    endtask

    function automatic led_req_t tick(input logic [1:0] cs, input logic [3:0] port,
                                      input int pct, input logic chip = 0,
                                      input logic ext = 0);
        led_req_t q;
        q.req_type = 1'b0;
        q.chg_state = cs;
        q.ext_power = ext;
        q.chipset_on = chip;
        q.active_port = port;
        q.battery_percent = pct[6:0];
        q.auto_enabled = 1'b1;
        return q;
    endfunction

    function automatic led_req_t rand_item();
        led_req_t q;
        q = led_req_t'(17'($urandom));
        q.req_type = ($urandom_range(0, 7) == 0);
        q.auto_enabled = ($urandom_range(0, 9) != 0);
        q.battery_percent = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                                        : 7'($urandom_range(0, 100));
        return q;
    endfunction

    // Every charge state, percent bands and extremes, taps and ignored ticks.
    task automatic test_directed();
        led_req_t q;
        int pcts[11] = '{0, 1, 3, 9, 14, 29, 89, 97, 100, 127, 50};
        send_item(tick(blps_pkg::CS_CHARGING, 4'd0, 50));
        send_item(tick(blps_pkg::CS_NEAR_FULL, 4'd1, 50));
        send_item(tick(blps_pkg::CS_DIS_FULL, 4'hF, 50, 1'b0, 1'b1));
        for (int i = 0; i < 11; i++)
        begin
            q = tick(blps_pkg::CS_OTHER, 4'd7, pcts[i]);
            q.req_type = (i % 3 == 0);
            send_item(q);
            send_item(tick(blps_pkg::CS_OTHER, i[0] ? 4'd8 : 4'd1, pcts[i], i[1]));
        end
        q = tick(blps_pkg::CS_OTHER, 4'd0, 50);
        q.auto_enabled = 1'b0;
        send_item(q);
    endtask

    task automatic test_hold();
        write_reg(blps_pkg::REG_MANUAL_HOLD, 2'd1);
        send_item(tick(blps_pkg::CS_CHARGING, 4'd0, 10));
        send_item(tick(blps_pkg::CS_OTHER, 4'd1, 0));
        write_reg(blps_pkg::REG_MANUAL_HOLD, 2'd0);
    endtask

    task automatic test_random(input int n);
        repeat (n) send_item(rand_item());
    endtask

    initial
    begin : limit
        #5ms;
        $display("tb_battery_led_pattern_sequencer_unit failed");
        $finish;
    end

    initial
    begin
        hold_q = 1'b0;
        min_soc_q = 2'd2;
        pat_q = blps_pkg::PAT_OFF;
        phase_q = 0;
        colour_q = blps_pkg::COL_OFF;
        tap_cnt_q = 0;
        tap_pend_q = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_hold();
        write_reg(blps_pkg::REG_MIN_SOC, 2'd0);
        send_item(tick(blps_pkg::CS_OTHER, 4'd0, 0, 1'b1));
        write_reg(blps_pkg::REG_MIN_SOC, 2'd1);
        test_random(35);
        write_reg(blps_pkg::REG_MIN_SOC, 2'd3);
        no_gaps = 1;
        test_random(20);
        no_gaps = 0;
        write_reg(blps_pkg::REG_MIN_SOC, 2'd2);
        test_random(35);
        wait_idle();
        if (fails == 0)
            $display("tb_battery_led_pattern_sequencer_unit passed");
        else
            $display("tb_battery_led_pattern_sequencer_unit failed");
        $finish;
    end
endmodule

[battery_led_pattern_sequencer_unit.f]
rtl/core/blps_pkg.sv
rtl/core/blps_ctrl.sv
rtl/core/blps_datapath.sv
rtl/core/battery_led_pattern_sequencer_unit.sv
test/tb_battery_led_pattern_sequencer_unit.sv
